// ----- src/lssds_pkg.sv -----
// Shared types and constants of the level-stacked slot distance store.
`timescale 1ns / 1ps
`default_nettype none
package lssds_pkg;

  // Fixed field widths
  localparam int OP_W       = 4;
  localparam int LEVEL_W    = 3;
  localparam int ID_W       = 20;
  localparam int TIX_W      = 4;
  localparam int DIST_W     = 32;
  localparam int CNT_W      = 5;
  localparam int LCO_W      = 4;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 96;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 2;

  localparam logic [ID_W-1:0] EMPTY_ID = '1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH    = 4'd0;
  localparam logic [OP_W-1:0] OP_SETBASE = 4'd1;
  localparam logic [OP_W-1:0] OP_WRITE   = 4'd2;
  localparam logic [OP_W-1:0] OP_FILL    = 4'd3;
  localparam logic [OP_W-1:0] OP_CLOSE   = 4'd4;
  localparam logic [OP_W-1:0] OP_REOPEN  = 4'd5;
  localparam logic [OP_W-1:0] OP_POP     = 4'd6;
  localparam logic [OP_W-1:0] OP_RSTSLOT = 4'd7;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 4'd8;
  localparam logic [OP_W-1:0] OP_READ    = 4'd9;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ILLEGAL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_CAPACITY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_MISS     = 2'd3;

  // Commands from controller to datapath
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_EXEC,
    CMD_LVL_RD,
    CMD_POP_RD,
    CMD_POP_LD,
    CMD_BASE_INIT,
    CMD_BASE_STEP,
    CMD_TGT_INIT,
    CMD_TGT_STEP,
    CMD_TRD_ISSUE,
    CMD_TRD_DONE,
    CMD_LOAD
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic search;
    logic reload;
    logic is_read;
    logic hit;
    logic miss;
    logic trd_bad;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- src/lssds_ctrl.sv -----
// Controller state machine: sequences each operation and owns the output valid.
`timescale 1ns / 1ps
`default_nettype none
module lssds_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output lssds_pkg::cmd_t        cmd,
  input  wire lssds_pkg::dp_stat_t stat
);
  import lssds_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_LVL, S_BASE, S_TINIT, S_TGT, S_TRD, S_TWAIT, S_RELOAD, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   out_free;

  assign out_free   = !out_tvalid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  // Pick the command and the next state
  always_comb begin
    cmd       = CMD_NONE;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd       = CMD_CAPTURE;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        priority if (stat.search) begin
          cmd       = CMD_LVL_RD;
          state_nxt = S_LVL;
        end else if (stat.reload) begin
          cmd       = CMD_POP_RD;
          state_nxt = S_RELOAD;
        end else begin
          cmd       = CMD_EXEC;
          state_nxt = S_OUT;
        end
      end
      S_RELOAD: begin
        cmd       = CMD_POP_LD;
        state_nxt = S_OUT;
      end
      S_LVL: begin
        cmd       = CMD_BASE_INIT;
        state_nxt = S_BASE;
      end
      S_BASE: begin
        cmd = CMD_BASE_STEP;
        priority if (stat.hit) state_nxt = S_TINIT;
        else if (stat.miss)    state_nxt = S_OUT;
        else                   state_nxt = S_BASE;
      end
      S_TINIT: begin
        cmd       = CMD_TGT_INIT;
        state_nxt = stat.is_read ? S_TRD : S_TGT;
      end
      S_TGT: begin
        cmd = CMD_TGT_STEP;
        if (stat.hit || stat.miss) state_nxt = S_OUT;
      end
      S_TRD: begin
        cmd       = CMD_TRD_ISSUE;
        state_nxt = stat.trd_bad ? S_OUT : S_TWAIT;
      end
      S_TWAIT: begin
        cmd       = CMD_TRD_DONE;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd       = CMD_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid: set on load, drop after the transfer
  always_comb begin
    if (cmd == CMD_LOAD)  out_tvalid_nxt = 1'b1;
    else if (out_tready)  out_tvalid_nxt = 1'b0;
    else                  out_tvalid_nxt = out_tvalid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/lssds_dp.sv -----
// Datapath: level table, slot base and target memories, search counter and result registers.
`timescale 1ns / 1ps
`default_nettype none
module lssds_dp #(
  parameter int MAX_LEVELS  = 8,
  parameter int MAX_SLOTS   = 16,
  parameter int MAX_TARGETS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire lssds_pkg::cmd_t                  cmd,
  output lssds_pkg::dp_stat_t                   stat,
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_wdata,
  input  wire logic [lssds_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic [lssds_pkg::IN_USER_W-1:0]  in_tuser,
  output logic      [lssds_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic      [lssds_pkg::OUT_USER_W-1:0] out_tuser
);
  import lssds_pkg::*;

  localparam int SLOT_TOTAL = MAX_LEVELS * MAX_SLOTS;
  localparam int TGT_TOTAL  = SLOT_TOTAL * MAX_TARGETS;
  localparam int LVW = $clog2(MAX_LEVELS + 1);
  localparam int LAW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int SCW = $clog2(MAX_SLOTS + 1);
  localparam int TCW = $clog2(MAX_TARGETS + 1);
  localparam int CW  = (SCW > TCW) ? SCW : TCW;
  localparam int SAW = $clog2(SLOT_TOTAL + 1);
  localparam int BAW = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
  localparam int TSW = $clog2(TGT_TOTAL + 1);
  localparam int TAW = (TGT_TOTAL > 1) ? $clog2(TGT_TOTAL) : 1;
  localparam int PW  = SCW + TCW;
  localparam logic [SCW-1:0] NONE_OPEN = SCW'(MAX_SLOTS);

  // Captured input item
  logic [OP_W-1:0]    op_r;
  logic [LEVEL_W-1:0] lv_r;
  logic [ID_W-1:0]    base_r, tid_r;
  logic [TIX_W-1:0]   tix_r;
  logic [DIST_W-1:0]  dist_r;
  logic [CNT_W-1:0]   sc_r, tc_in_r;

  // Stack state
  logic           use_r;
  logic [LVW-1:0] lc_r;
  logic [SCW-1:0] open_r;
  logic [SAW-1:0] top_ss_r, top_se_r;
  logic [TSW-1:0] top_ts_r, top_te_r;
  logic [TCW-1:0] top_tc_r;

  // Level table memory
  logic [SAW-1:0] lss_mem [MAX_LEVELS];
  logic [SAW-1:0] lse_mem [MAX_LEVELS];
  logic [TSW-1:0] lts_mem [MAX_LEVELS];
  logic [TSW-1:0] lte_mem [MAX_LEVELS];
  logic [TCW-1:0] ltc_mem [MAX_LEVELS];
  logic [SAW-1:0] lq_ss, lq_se;
  logic [TSW-1:0] lq_ts, lq_te;
  logic [TCW-1:0] lq_tc;
  logic           lrd_en;
  logic [LAW-1:0] lrd_addr;

  // Data memories
  logic [ID_W-1:0]   bases_mem [SLOT_TOTAL];
  logic [DIST_W-1:0] dist_mem  [TGT_TOTAL];
  logic [ID_W-1:0]   ids_mem   [TGT_TOTAL];
  logic [ID_W-1:0]   bases_q, ids_q;
  logic [DIST_W-1:0] dist_q;
  logic              brd_en, trd_en;
  logic [BAW-1:0]    brd_addr, bwr_addr;
  logic [TAW-1:0]    trd_addr, twr_addr;

  // Search registers
  logic [SAW-1:0] ss_r;
  logic [TSW-1:0] ts_r, tbase_r;
  logic [TCW-1:0] tc_r;
  logic [SCW-1:0] off_r;
  logic [CW-1:0]  cnt_r, lim_r, rd_idx_r;
  logic           rd_vld_r, tgt_mode_r;

  // Result and output registers
  logic              res_found_r;
  logic [DIST_W-1:0] res_dist_r;
  logic [ID_W-1:0]   res_tid_r;
  logic [STAT_W-1:0] res_st_r;
  logic              o_found_r;
  logic [DIST_W-1:0] o_dist_r;
  logic [ID_W-1:0]   o_tid_r;
  logic [STAT_W-1:0] o_st_r;
  logic [LCO_W-1:0]  o_lc_r;
  logic [CNT_W-1:0]  o_open_r, o_top_r;

  // Operation evaluation
  logic              is_open;
  logic [SCW-1:0]    top_slots;
  logic [PW-1:0]     open_x_tc, off_x_tc;
  logic [2*CNT_W-1:0] push_prod;
  logic [STAT_W-1:0] ex_st;
  logic [LVW-1:0]    lc_x;
  logic [SCW-1:0]    open_x;
  logic [SAW-1:0]    ss_x, se_x;
  logic [TSW-1:0]    ts_x, te_x;
  logic [TCW-1:0]    tc_x;
  logic              lw_en, bw_en, tw_en;
  logic [LAW-1:0]    lw_addr;
  logic [SAW-1:0]    lim_slots;
  logic [CW-1:0]     lim_x;
  logic              cmp_eq;

  assign is_open   = (open_r != NONE_OPEN);
  assign top_slots = SCW'(top_se_r - top_ss_r);
  assign open_x_tc = PW'(open_r) * PW'(top_tc_r);
  assign off_x_tc  = PW'(off_r) * PW'(tc_r);
  assign push_prod = (2*CNT_W)'(sc_r) * (2*CNT_W)'(tc_in_r);

  // Decode status for the controller
  always_comb begin
    stat.search  = ((op_r == OP_LOOKUP) || (op_r == OP_READ)) && (lv_r < lc_r) &&
                   (base_r != EMPTY_ID) && !((op_r == OP_LOOKUP) && !use_r);
    stat.reload  = (op_r == OP_POP) && (lc_r >= 2);
    stat.is_read = (op_r == OP_READ);
    cmp_eq       = tgt_mode_r ? (ids_q == tid_r) : (bases_q == base_r);
    stat.hit     = rd_vld_r && cmp_eq;
    stat.miss    = !rd_vld_r && (cnt_r >= lim_r);
    stat.trd_bad = (tix_r >= tc_r);
  end

  // Evaluate a non-search operation against the top level
  always_comb begin
    ex_st   = STAT_OK;
    lc_x    = lc_r;
    open_x  = open_r;
    ss_x    = top_ss_r;
    se_x    = top_se_r;
    ts_x    = top_ts_r;
    te_x    = top_te_r;
    tc_x    = top_tc_r;
    lw_en   = 1'b0;
    bw_en   = 1'b0;
    tw_en   = 1'b0;
    lw_addr = LAW'(lc_r - 1'b1);
    unique case (op_r)
      OP_PUSH: begin
        priority if (is_open) begin
          ex_st = STAT_ILLEGAL;
        end else if ((lc_r == LVW'(MAX_LEVELS)) || (sc_r == '0) || (sc_r > MAX_SLOTS) ||
                     (tc_in_r > MAX_TARGETS)) begin
          ex_st = STAT_CAPACITY;
        end else begin
          ss_x    = (lc_r == '0) ? '0 : top_se_r;
          se_x    = ss_x + SAW'(sc_r);
          ts_x    = (lc_r == '0) ? '0 : top_te_r;
          te_x    = ts_x + TSW'(push_prod);
          tc_x    = TCW'(tc_in_r);
          lc_x    = lc_r + 1'b1;
          open_x  = '0;
          lw_en   = 1'b1;
          lw_addr = LAW'(lc_r);
        end
      end
      OP_SETBASE: begin
        if (!is_open) ex_st = STAT_ILLEGAL;
        else          bw_en = 1'b1;
      end
      OP_WRITE: begin
        priority if (!is_open)        ex_st = STAT_ILLEGAL;
        else if (tix_r >= top_tc_r)   ex_st = STAT_CAPACITY;
        else                          tw_en = 1'b1;
      end
      OP_FILL: begin
        if (!is_open) begin
          ex_st = STAT_ILLEGAL;
        end else begin
          open_x = open_r + 1'b1;
          if (open_x >= top_slots) open_x = NONE_OPEN;
        end
      end
      OP_CLOSE: begin
        if (lc_r == '0) begin
          ex_st = STAT_ILLEGAL;
        end else if (is_open) begin
          se_x   = top_ss_r + SAW'(open_r);
          te_x   = top_ts_r + TSW'(open_x_tc);
          open_x = NONE_OPEN;
          lw_en  = 1'b1;
        end
      end
      OP_REOPEN: begin
        priority if ((lc_r == '0) || is_open) begin
          ex_st = STAT_ILLEGAL;
        end else if (top_slots >= SCW'(MAX_SLOTS)) begin
          ex_st = STAT_CAPACITY;
        end else begin
          open_x = top_slots;
          se_x   = top_se_r + 1'b1;
          te_x   = top_te_r + TSW'(top_tc_r);
          lw_en  = 1'b1;
        end
      end
      OP_POP: begin
        if (lc_r == '0) begin
          ex_st = STAT_ILLEGAL;
        end else begin
          lc_x   = lc_r - 1'b1;
          open_x = NONE_OPEN;
        end
      end
      OP_RSTSLOT: begin
        if (!is_open) ex_st = STAT_ILLEGAL;
      end
      default: ex_st = STAT_ILLEGAL;
    endcase
  end

  // Search limit: only filled slots on the open top level
  always_comb begin
    lim_slots = lq_se - lq_ss;
    lim_x     = CW'(lim_slots);
    if (((32'(lv_r) + 32'd1) == 32'(lc_r)) && is_open && (SAW'(open_r) < lim_slots)) begin
      lim_x = CW'(open_r);
    end
  end

  // Memory ports
  always_comb begin
    lrd_en   = (cmd == CMD_LVL_RD) || (cmd == CMD_POP_RD);
    lrd_addr = (cmd == CMD_POP_RD) ? LAW'(lc_r - 2'd2) : LAW'(lv_r);
    bwr_addr = BAW'(top_ss_r + SAW'(open_r));
    twr_addr = TAW'(top_ts_r + TSW'(open_x_tc) + TSW'(tix_r));
    brd_en   = (cmd == CMD_BASE_STEP) && !stat.hit && (cnt_r < lim_r);
    brd_addr = BAW'(ss_r + SAW'(cnt_r));
    trd_en   = ((cmd == CMD_TGT_STEP) && !stat.hit && (cnt_r < lim_r)) ||
               ((cmd == CMD_TRD_ISSUE) && !stat.trd_bad);
    trd_addr = (cmd == CMD_TRD_ISSUE) ? TAW'(tbase_r + TSW'(tix_r))
                                      : TAW'(tbase_r + TSW'(cnt_r));
  end

  // Level table: write through on every top-level change
  always_ff @(posedge clk) begin
    if ((cmd == CMD_EXEC) && lw_en) begin
      lss_mem[lw_addr] <= ss_x;
      lse_mem[lw_addr] <= se_x;
      lts_mem[lw_addr] <= ts_x;
      lte_mem[lw_addr] <= te_x;
      ltc_mem[lw_addr] <= tc_x;
    end
    if (lrd_en) begin
      lq_ss <= lss_mem[lrd_addr];
      lq_se <= lse_mem[lrd_addr];
      lq_ts <= lts_mem[lrd_addr];
      lq_te <= lte_mem[lrd_addr];
      lq_tc <= ltc_mem[lrd_addr];
    end
  end

  // Slot base memory
  always_ff @(posedge clk) begin
    if ((cmd == CMD_EXEC) && bw_en) bases_mem[bwr_addr] <= base_r;
    if (brd_en)                     bases_q <= bases_mem[brd_addr];
  end

  // Target memories
  always_ff @(posedge clk) begin
    if ((cmd == CMD_EXEC) && tw_en) begin
      dist_mem[twr_addr] <= dist_r;
      if (use_r) ids_mem[twr_addr] <= tid_r;
    end
    if (trd_en) begin
      dist_q <= dist_mem[trd_addr];
      ids_q  <= ids_mem[trd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r    <= 1'b1;
      lc_r     <= '0;
      open_r   <= NONE_OPEN;
      rd_vld_r <= 1'b0;
    end else begin
      if (cfg_we) use_r <= cfg_wdata;
      unique case (cmd)
        CMD_EXEC: begin
          lc_r   <= lc_x;
          open_r <= open_x;
        end
        CMD_POP_RD: begin
          lc_r   <= lc_r - 1'b1;
          open_r <= NONE_OPEN;
        end
        CMD_BASE_INIT, CMD_TGT_INIT: rd_vld_r <= 1'b0;
        CMD_BASE_STEP, CMD_TGT_STEP: rd_vld_r <= !stat.hit && (cnt_r < lim_r);
        default: ;
      endcase
    end
  end

  // Payload: captured item, top record, search registers, results
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_CAPTURE: begin
        op_r    <= in_tuser[OP_W-1:0];
        lv_r    <= in_tdata[2:0];
        base_r  <= in_tdata[22:3];
        tid_r   <= in_tdata[42:23];
        tix_r   <= in_tdata[46:43];
        dist_r  <= in_tdata[78:47];
        sc_r    <= in_tdata[83:79];
        tc_in_r <= in_tdata[88:84];
      end
      CMD_EXEC: begin
        top_ss_r    <= ss_x;
        top_se_r    <= se_x;
        top_ts_r    <= ts_x;
        top_te_r    <= te_x;
        top_tc_r    <= tc_x;
        res_found_r <= 1'b0;
        res_dist_r  <= '0;
        res_tid_r   <= '0;
        res_st_r    <= ex_st;
      end
      CMD_POP_RD: begin
        res_found_r <= 1'b0;
        res_dist_r  <= '0;
        res_tid_r   <= '0;
        res_st_r    <= STAT_OK;
      end
      CMD_POP_LD: begin
        top_ss_r <= lq_ss;
        top_se_r <= lq_se;
        top_ts_r <= lq_ts;
        top_te_r <= lq_te;
        top_tc_r <= lq_tc;
      end
      CMD_BASE_INIT: begin
        ss_r       <= lq_ss;
        ts_r       <= lq_ts;
        tc_r       <= lq_tc;
        lim_r      <= lim_x;
        cnt_r      <= '0;
        tgt_mode_r <= 1'b0;
      end
      CMD_BASE_STEP: begin
        priority if (stat.hit) begin
          off_r <= SCW'(rd_idx_r);
        end else if (cnt_r < lim_r) begin
          rd_idx_r <= cnt_r;
          cnt_r    <= cnt_r + 1'b1;
        end else if (stat.miss) begin
          res_found_r <= 1'b0;
          res_dist_r  <= '0;
          res_tid_r   <= '0;
          res_st_r    <= STAT_MISS;
        end
      end
      CMD_TGT_INIT: begin
        tbase_r    <= ts_r + TSW'(off_x_tc);
        lim_r      <= CW'(tc_r);
        cnt_r      <= '0;
        tgt_mode_r <= 1'b1;
      end
      CMD_TGT_STEP: begin
        priority if (stat.hit) begin
          res_found_r <= 1'b1;
          res_dist_r  <= dist_q;
          res_tid_r   <= '0;
          res_st_r    <= STAT_OK;
        end else if (cnt_r < lim_r) begin
          rd_idx_r <= cnt_r;
          cnt_r    <= cnt_r + 1'b1;
        end else if (stat.miss) begin
          res_found_r <= 1'b0;
          res_dist_r  <= '0;
          res_tid_r   <= '0;
          res_st_r    <= STAT_MISS;
        end
      end
      CMD_TRD_ISSUE: begin
        if (stat.trd_bad) begin
          res_found_r <= 1'b0;
          res_dist_r  <= '0;
          res_tid_r   <= '0;
          res_st_r    <= STAT_CAPACITY;
        end
      end
      CMD_TRD_DONE: begin
        res_found_r <= 1'b1;
        res_dist_r  <= dist_q;
        res_tid_r   <= use_r ? ids_q : '0;
        res_st_r    <= STAT_OK;
      end
      CMD_LOAD: begin
        o_found_r <= res_found_r;
        o_dist_r  <= res_dist_r;
        o_tid_r   <= res_tid_r;
        o_st_r    <= res_st_r;
        o_lc_r    <= LCO_W'(lc_r);
        o_open_r  <= CNT_W'(open_r);
        o_top_r   <= (lc_r != '0) ? CNT_W'(top_slots) : '0;
      end
      default: ;
    endcase
  end

  assign out_tdata = {5'd0, o_top_r, o_open_r, o_lc_r, o_tid_r, o_dist_r, o_found_r};
  assign out_tuser = o_st_r;

endmodule
`default_nettype wire

// ----- src/level_stacked_slot_distance_store_top.sv -----
// Top level of the level-stacked slot distance store.
// Usage:
//   One command per transfer on the in_ channel: in_tuser carries the op code,
//   in_tdata the operands. Every command gives exactly one result transfer on
//   the out_ channel: found, distance, target id and the stack status in
//   out_tdata, the status code in out_tuser.
//   cfg_we/cfg_wdata write the use_target_ids bit; write it only while idle.
//   Items are handled one at a time. Stack edits (push, set base, write target,
//   fill, close, reopen, pop, reset slot) are executed in the decode state and
//   loaded into the output register in the output state; a pop that uncovers a
//   lower level reloads the top record from the level table in between.
//   Lookup walks the slot bases of the level one memory read per cycle, then
//   the target ids of the matched slot the same way. Readtarget replaces the
//   target walk with a single read.
//   The next command is taken the cycle after a result is loaded into the
//   output register, even while the receiver stalls it; the result waits there
//   until out_tready, and the next result waits behind it.
//   Reset (rst_n low, synchronous) empties the stack, closes the open slot and
//   sets use_target_ids; memory contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module level_stacked_slot_distance_store_top #(
  parameter int MAX_LEVELS  = 8,
  parameter int MAX_SLOTS   = 16,
  parameter int MAX_TARGETS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_wdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // level[2:0], base_id[22:3], target_id[42:23], target_index[46:43],
  // distance[78:47], slot_count[83:79], target_count[88:84]
  input  wire logic [lssds_pkg::IN_DATA_W-1:0]  in_tdata,
  // op[3:0]
  input  wire logic [lssds_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // found[0], distance_out[32:1], target_id_out[52:33], level_count_out[56:53],
  // open_slot_out[61:57], top_slot_count[66:62]
  output logic      [lssds_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic      [lssds_pkg::OUT_USER_W-1:0] out_tuser
);
  import lssds_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  lssds_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  lssds_dp #(
    .MAX_LEVELS  (MAX_LEVELS),
    .MAX_SLOTS   (MAX_SLOTS),
    .MAX_TARGETS (MAX_TARGETS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
`default_nettype wire

// ----- src/lssds_chk.sv -----
// Port-level checker for the slot distance store, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lssds_chk #(
  parameter int MAX_LEVELS = 8
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [lssds_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [lssds_pkg::OUT_USER_W-1:0] out_tuser
);
  import lssds_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // One item at a time: busy right after a transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a command is in flight");

  // A found result always carries status ok
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tuser == STAT_OK)
    else $error("found with non-ok status");

  // Failed commands return a zero distance and the level count stays in range
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STAT_OK) |->
      (out_tdata[32:1] == '0) && (out_tdata[56:53] <= MAX_LEVELS))
    else $error("failed command returned data");

endmodule

bind level_stacked_slot_distance_store_top lssds_chk #(
  .MAX_LEVELS (MAX_LEVELS)
) u_lssds_chk (.*);
`default_nettype wire

// ----- tb/tb_level_stacked_slot_distance_store_top.sv -----
// Self-checking testbench for the level-stacked slot distance store.
`timescale 1ns / 1ps
module tb_level_stacked_slot_distance_store_top;
  import lssds_pkg::*;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [LEVEL_W-1:0] lvl;
    logic [ID_W-1:0]    base;
    logic [ID_W-1:0]    tid;
    logic [TIX_W-1:0]   tix;
    logic [DIST_W-1:0]  dval;
    logic [CNT_W-1:0]   sc;
    logic [CNT_W-1:0]   tc;
  } store_cmd_t;

  typedef struct packed {
    logic               found;
    logic [DIST_W-1:0]  dval;
    logic [ID_W-1:0]    tid;
    logic [STAT_W-1:0]  status;
    logic [LCO_W-1:0]   lcount;
    logic [CNT_W-1:0]   oslot;
    logic [CNT_W-1:0]   tslots;
  } store_resp_t;

  localparam int NSLOT = 16;
  localparam int NONE_OPEN = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  level_stacked_slot_distance_store_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted store state
  int unsigned slot_start[0:8];
  int unsigned tgt_start[0:8];
  int unsigned tgt_per_slot[0:7];
  int unsigned lvl_count;
  int unsigned open_idx;
  bit ids_on;
  logic [ID_W-1:0]   base_mem[0:127];
  bit                base_set[0:127];
  logic [DIST_W-1:0] dist_mem[0:2047];
  bit                dist_set[0:2047];
  logic [ID_W-1:0]   id_mem[0:2047];
  bit                id_set[0:2047];
  // generator bookkeeping for the open slot
  bit open_has_base;
  int unsigned next_tix;

  store_cmd_t  pending_cmds[$];
  store_resp_t expected_resps[$];
  int unsigned fail_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_phase = 1'b0;
  bit hold_done = 1'b0;
  int unsigned hold_cycles = 0;

  function automatic int unsigned slots_of(int unsigned lv);
    return slot_start[lv+1] - slot_start[lv];
  endfunction

  function automatic int unsigned search_limit(int unsigned lv);
    int unsigned lim;
    lim = slots_of(lv);
    if (lv + 1 == lvl_count && open_idx != NONE_OPEN && open_idx < lim) lim = open_idx;
    return lim;
  endfunction

  function automatic int find_slot(int unsigned lv, logic [ID_W-1:0] b);
    for (int unsigned i = 0; i < search_limit(lv); i++)
      if (base_mem[slot_start[lv] + i] == b) return i;
    return -1;
  endfunction

  // True when a lookup or read would touch only written memory
  function automatic bit touches_written(store_cmd_t c);
    int off;
    int unsigned nt, p;
    if (c.op != OP_LOOKUP && c.op != OP_READ) return 1;
    if (c.lvl >= lvl_count || c.base == EMPTY_ID || (c.op == OP_LOOKUP && !ids_on)) return 1;
    for (int unsigned i = 0; i < search_limit(c.lvl); i++)
      if (!base_set[slot_start[c.lvl] + i]) return 0;
    off = find_slot(c.lvl, c.base);
    if (off < 0) return 1;
    nt = tgt_per_slot[c.lvl];
    p = tgt_start[c.lvl] + off * nt;
    if (c.op == OP_LOOKUP) begin
      for (int unsigned i = 0; i < nt; i++)
        if (!id_set[p+i] || !dist_set[p+i]) return 0;
      return 1;
    end
    if (c.tix >= nt) return 1;
    return dist_set[p+c.tix] && id_set[p+c.tix];
  endfunction

  // Apply one command to the predicted state and return its result
  function automatic store_resp_t apply_cmd(store_cmd_t c);
    store_resp_t r;
    bit is_open;
    int unsigned top, nt, p;
    int off;
    r = '0;
    is_open = (open_idx != NONE_OPEN);
    top = lvl_count ? lvl_count - 1 : 0;
    case (c.op)
      OP_PUSH: begin
        if (is_open) r.status = STAT_ILLEGAL;
        else if (lvl_count >= 8 || c.sc == 0 || c.sc > NSLOT || c.tc > 16)
          r.status = STAT_CAPACITY;
        else begin
          lvl_count++;
          slot_start[lvl_count] = slot_start[lvl_count-1] + c.sc;
          tgt_start[lvl_count] = tgt_start[lvl_count-1] + c.sc * c.tc;
          tgt_per_slot[lvl_count-1] = c.tc;
          open_idx = 0;
        end
      end
      OP_SETBASE: begin
        if (!is_open) r.status = STAT_ILLEGAL;
        else begin
          p = slot_start[top] + open_idx;
          base_mem[p] = c.base;
          base_set[p] = 1;
        end
      end
      OP_WRITE: begin
        nt = tgt_per_slot[top];
        if (!is_open) r.status = STAT_ILLEGAL;
        else if (c.tix >= nt) r.status = STAT_CAPACITY;
        else begin
          p = tgt_start[top] + open_idx * nt + c.tix;
          dist_mem[p] = c.dval;
          dist_set[p] = 1;
          if (ids_on) begin
            id_mem[p] = c.tid;
            id_set[p] = 1;
          end
        end
      end
      OP_FILL: begin
        if (!is_open) r.status = STAT_ILLEGAL;
        else begin
          open_idx++;
          if (open_idx >= slots_of(top)) open_idx = NONE_OPEN;
        end
      end
      OP_CLOSE: begin
        if (lvl_count == 0) r.status = STAT_ILLEGAL;
        else if (is_open) begin
          slot_start[lvl_count] = slot_start[top] + open_idx;
          tgt_start[lvl_count] = tgt_start[top] + open_idx * tgt_per_slot[top];
          open_idx = NONE_OPEN;
        end
      end
      OP_REOPEN: begin
        if (lvl_count == 0 || is_open) r.status = STAT_ILLEGAL;
        else if (slots_of(top) >= NSLOT) r.status = STAT_CAPACITY;
        else begin
          open_idx = slots_of(top);
          slot_start[lvl_count]++;
          tgt_start[lvl_count] += tgt_per_slot[top];
        end
      end
      OP_POP: begin
        if (lvl_count == 0) r.status = STAT_ILLEGAL;
        else begin
          lvl_count--;
          open_idx = NONE_OPEN;
        end
      end
      OP_RSTSLOT: if (!is_open) r.status = STAT_ILLEGAL;
      OP_LOOKUP, OP_READ: begin
        if (c.lvl >= lvl_count || c.base == EMPTY_ID || (c.op == OP_LOOKUP && !ids_on))
          r.status = STAT_ILLEGAL;
        else begin
          off = find_slot(c.lvl, c.base);
          nt = tgt_per_slot[c.lvl];
          if (off < 0) r.status = STAT_MISS;
          else if (c.op == OP_LOOKUP) begin
            p = tgt_start[c.lvl] + off * nt;
            r.status = STAT_MISS;
            for (int unsigned i = 0; i < nt; i++)
              if (r.found == 0 && id_mem[p+i] == c.tid) begin
                r.found = 1;
                r.dval = dist_mem[p+i];
                r.status = STAT_OK;
              end
          end else if (c.tix >= nt) r.status = STAT_CAPACITY;
          else begin
            p = tgt_start[c.lvl] + off * nt + c.tix;
            r.found = 1;
            r.dval = dist_mem[p];
            r.tid = ids_on ? id_mem[p] : '0;
          end
        end
      end
      default: r.status = STAT_ILLEGAL;
    endcase
    r.lcount = lvl_count;
    r.oslot = open_idx;
    r.tslots = lvl_count ? slots_of(lvl_count - 1) : 0;
    return r;
  endfunction

  // Queue a command with its expected result; unsafe searches use the empty base
  task automatic issue(store_cmd_t c);
    if (!touches_written(c)) c.base = EMPTY_ID;
    if (c.op == OP_PUSH && open_idx == NONE_OPEN) begin
      open_has_base = 0;
      next_tix = 0;
    end
    if (c.op == OP_FILL || c.op == OP_REOPEN) begin
      open_has_base = 0;
      next_tix = 0;
    end
    expected_resps.push_back(apply_cmd(c));
    pending_cmds.push_back(c);
  endtask

  function automatic store_cmd_t noise_cmd();
    store_cmd_t c;
    c = {$urandom, $urandom, $urandom};
    c.op = $urandom_range(0, 15);
    return c;
  endfunction

  function automatic store_cmd_t search_cmd();
    store_cmd_t c;
    c = noise_cmd();
    c.op = $urandom_range(0, 1) ? OP_LOOKUP : OP_READ;
    c.lvl = lvl_count ? $urandom_range(0, lvl_count - 1) : $urandom_range(0, 7);
    if ($urandom_range(0, 9) == 0) c.lvl = $urandom_range(0, 7);
    c.base = ($urandom_range(0, 19) == 0) ? EMPTY_ID : $urandom_range(0, 5);
    c.tid = $urandom_range(0, 5);
    c.tix = $urandom_range(0, 4);
    return c;
  endfunction

  // Mostly well-formed level building with random content
  task automatic issue_random();
    store_cmd_t c;
    int unsigned pick;
    c = noise_cmd();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      issue(c);
      return;
    end
    if (open_idx != NONE_OPEN) begin
      if (pick < 80) begin
        if (!open_has_base) begin
          c.op = OP_SETBASE;
          c.base = $urandom_range(0, 7) == 0 ? EMPTY_ID : $urandom_range(0, 5);
          open_has_base = 1;
        end else if (next_tix < tgt_per_slot[lvl_count-1]) begin
          c.op = OP_WRITE;
          c.tix = next_tix;
          c.tid = $urandom_range(0, 5);
          next_tix++;
        end else c.op = OP_FILL;
      end else if (pick < 93) c = search_cmd();
      else begin
        case ($urandom_range(0, 4))
          0: c.op = OP_CLOSE;
          1: c.op = OP_POP;
          2: c.op = OP_RSTSLOT;
          3: c.op = OP_PUSH;
          default: c.op = OP_REOPEN;
        endcase
      end
    end else begin
      if (pick < 40 && lvl_count < 8) begin
        c.op = OP_PUSH;
        c.sc = ($urandom_range(0, 15) == 0) ? 16 : $urandom_range(1, 4);
        c.tc = ($urandom_range(0, 15) == 0) ? 16 : $urandom_range(0, 4);
      end else if (pick < 58) c.op = OP_POP;
      else if (pick < 66) c.op = OP_REOPEN;
      else c = search_cmd();
    end
    issue(c);
  endtask

  task automatic issue_op(logic [OP_W-1:0] op, int unsigned lvl, logic [ID_W-1:0] base,
                          logic [ID_W-1:0] tid, int unsigned tix, logic [DIST_W-1:0] dv,
                          int unsigned sc, int unsigned tc);
    store_cmd_t c;
    c.op = op; c.lvl = lvl; c.base = base; c.tid = tid; c.tix = tix;
    c.dval = dv; c.sc = sc; c.tc = tc;
    issue(c);
  endtask

  task automatic write_use_ids(bit v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ids_on = v;
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && expected_resps.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  // Driver: present the next pending command, hold it until the transfer
  always @(posedge clk) begin
    if (!rst_n) in_tvalid <= 1'b0;
    else if (!in_tvalid || in_tready) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tuser <= pending_cmds[0].op;
        in_tdata <= {7'd0, pending_cmds[0].tc, pending_cmds[0].sc, pending_cmds[0].dval,
                     pending_cmds[0].tix, pending_cmds[0].tid, pending_cmds[0].base,
                     pending_cmds[0].lvl};
        void'(pending_cmds.pop_front());
      end else in_tvalid <= 1'b0;
    end
  end

  // Receiver ready, with one long hold-off in the pressure phase
  always @(posedge clk) begin
    if (hold_phase && !hold_done) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles == 400) hold_done <= 1'b1;
    end else out_tready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    store_resp_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_resps.size() == 0) begin
        $error("unexpected result transfer");
        fail_count++;
      end else begin
        e = expected_resps.pop_front();
        if (out_tdata[0] !== e.found) begin
          $error("found exp %0d got %0d", e.found, out_tdata[0]); fail_count++;
        end
        if (out_tdata[32:1] !== e.dval) begin
          $error("distance_out exp %0h got %0h", e.dval, out_tdata[32:1]); fail_count++;
        end
        if (out_tdata[52:33] !== e.tid) begin
          $error("target_id_out exp %0h got %0h", e.tid, out_tdata[52:33]); fail_count++;
        end
        if (out_tuser !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_tuser); fail_count++;
        end
        if (out_tdata[56:53] !== e.lcount) begin
          $error("level_count_out exp %0d got %0d", e.lcount, out_tdata[56:53]); fail_count++;
        end
        if (out_tdata[61:57] !== e.oslot) begin
          $error("open_slot_out exp %0d got %0d", e.oslot, out_tdata[61:57]); fail_count++;
        end
        if (out_tdata[66:62] !== e.tslots) begin
          $error("top_slot_count exp %0d got %0d", e.tslots, out_tdata[66:62]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    slot_start[0] = 0;
    tgt_start[0] = 0;
    lvl_count = 0;
    open_idx = NONE_OPEN;
    ids_on = 1;
    open_has_base = 0;
    next_tix = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    write_use_ids(1'b1);

    // Directed: empty-stack errors, bad pushes, full-size level, edge fields
    issue_op(OP_CLOSE, 0, 0, 0, 0, 0, 0, 0);
    issue_op(OP_POP, 0, 0, 0, 0, 0, 0, 0);
    issue_op(OP_REOPEN, 0, 0, 0, 0, 0, 0, 0);
    issue_op(OP_SETBASE, 0, 1, 0, 0, 0, 0, 0);
    issue_op(OP_FILL, 0, 0, 0, 0, 0, 0, 0);
    issue_op(OP_RSTSLOT, 0, 0, 0, 0, 0, 0, 0);
    issue_op(4'd10, 7, EMPTY_ID, EMPTY_ID, 15, '1, 31, 31);
    issue_op(4'd15, 0, 0, 0, 0, 0, 0, 0);
    issue_op(OP_PUSH, 0, 0, 0, 0, 0, 0, 1);
    issue_op(OP_PUSH, 0, 0, 0, 0, 0, 17, 1);
    issue_op(OP_PUSH, 0, 0, 0, 0, 0, 1, 17);
    issue_op(OP_PUSH, 0, 0, 0, 0, 0, 16, 16);
    issue_op(OP_PUSH, 0, 0, 0, 0, 0, 1, 1);
    issue_op(OP_SETBASE, 0, EMPTY_ID - 1, 0, 0, 0, 0, 0);
    issue_op(OP_WRITE, 0, 0, EMPTY_ID, 15, '1, 0, 0);
    issue_op(OP_WRITE, 0, 0, 0, 0, 0, 0, 0);
    issue_op(OP_RSTSLOT, 0, 0, 0, 0, 0, 0, 0);
    issue_op(OP_LOOKUP, 0, EMPTY_ID - 1, 0, 0, 0, 0, 0);
    issue_op(OP_CLOSE, 0, 0, 0, 0, 0, 0, 0);
    issue_op(OP_REOPEN, 0, 0, 0, 0, 0, 0, 0);
    issue_op(OP_POP, 0, 0, 0, 0, 0, 0, 0);
    drain();

    // Random phases: idling mix, register setting and pressure vary by phase
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 57; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 57; end
        3: begin send_idle_pct = 37; recv_stall_pct = 37; end
        default: begin send_idle_pct = 0; recv_stall_pct = 20; hold_phase = 1'b1; end
      endcase
      write_use_ids(ph % 2 == 0);
      for (int n = 0; n < 200; n++) issue_random();
      drain();
    end

    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

// ----- level_stacked_slot_distance_store_top.f -----
src/lssds_pkg.sv
src/lssds_ctrl.sv
src/lssds_dp.sv
src/level_stacked_slot_distance_store_top.sv
src/lssds_chk.sv
tb/tb_level_stacked_slot_distance_store_top.sv
